/* rtl/core/c8x_pkg.sv */
// Shared types and constants for the CHIP-8 instruction execute core.
// No dependencies; every other file in rtl/core imports this package.
package c8x_pkg;

  localparam int unsigned REG_COUNT  = 16;
  localparam int unsigned REG_AW     = $clog2(REG_COUNT);
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [ADDR_W-1:0] START_RESET = 12'h200;
  localparam logic [ADDR_W-1:0] PC_STEP     = 12'd2;
  localparam logic [ADDR_W-1:0] PC_SKIP     = 12'd4;

  // Whole-word system instructions
  localparam logic [WORD_W-1:0] INSTR_CLS = 16'h00E0;
  localparam logic [WORD_W-1:0] INSTR_RET = 16'h00EE;

  // Major opcodes (top nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEB  = 4'h3;
  localparam logic [3:0] OP_SNEB = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDB  = 4'h6;
  localparam logic [3:0] OP_ADDB = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;

  // Register-to-register group (low nibble of 8xyN)
  localparam logic [3:0] ALU_LD  = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNIMPL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HALT   = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]   next_pc;
    logic [ADDR_W-1:0]   index_value;
    logic                halted;
    logic [STATUS_W-1:0] status;
    logic                reg_written;
    logic [REG_AW-1:0]   written_index;
    logic [DATA_W-1:0]   written_value;
  } exec_res_t;

endpackage

/* rtl/core/c8x_if.sv */
// Valid/ready channel interfaces for instruction words and result words.
// Depends on c8x_pkg for field widths.
interface c8x_instr_if;
  import c8x_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   instruction_word;
  logic [DATA_W-1:0]   random_byte;
  modport source (output valid, output instruction_word, output random_byte, input ready);
  modport sink   (input valid, input instruction_word, input random_byte, output ready);
endinterface

interface c8x_result_if;
  import c8x_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   next_pc;
  logic [STATUS_W-1:0] status;
  logic                reg_written;
  logic [REG_AW-1:0]   written_index;
  logic [DATA_W-1:0]   written_value;
  logic [ADDR_W-1:0]   index_value;
  modport source (output valid, output next_pc, output status, output reg_written,
                  output written_index, output written_value, output index_value,
                  input ready);
  modport sink   (input valid, input next_pc, input status, input reg_written,
                  input written_index, input written_value, input index_value,
                  output ready);
endinterface

/* rtl/core/c8x_regfile.sv */
// V0..VF register file: synchronous memory, two read ports, one write port.
// Depends on c8x_pkg. Forwards a write that lands on the same edge as a read.
module c8x_regfile (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [c8x_pkg::REG_AW-1:0] rd_addr_a,
  input  logic [c8x_pkg::REG_AW-1:0] rd_addr_b,
  output logic [c8x_pkg::DATA_W-1:0] rd_data_a,
  output logic [c8x_pkg::DATA_W-1:0] rd_data_b,
  input  logic                      wr_en,
  input  logic [c8x_pkg::REG_AW-1:0] wr_addr,
  input  logic [c8x_pkg::DATA_W-1:0] wr_data
);
  import c8x_pkg::*;

  logic [DATA_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] written;

  logic [DATA_W-1:0] q_a, q_b, fwd_data;
  logic              hit_a, hit_b, vld_a, vld_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a      <= mem[rd_addr_a];
      q_b      <= mem[rd_addr_b];
      vld_a    <= written[rd_addr_a];
      vld_b    <= written[rd_addr_b];
      hit_a    <= wr_en && (wr_addr == rd_addr_a);
      hit_b    <= wr_en && (wr_addr == rd_addr_b);
      fwd_data <= wr_data;
    end
  end

  assign rd_data_a = hit_a ? fwd_data : (vld_a ? q_a : '0);
  assign rd_data_b = hit_b ? fwd_data : (vld_b ? q_b : '0);

endmodule

/* rtl/core/c8x_exec.sv */
// Instruction decode and execute logic for one CHIP-8 instruction.
// Depends on c8x_pkg; pure combinational, state lives in the top level.
module c8x_exec (
  input  logic [c8x_pkg::WORD_W-1:0] instruction_word,
  input  logic [c8x_pkg::DATA_W-1:0] random_byte,
  input  logic [c8x_pkg::DATA_W-1:0] vx,
  input  logic [c8x_pkg::DATA_W-1:0] vy,
  input  logic [c8x_pkg::ADDR_W-1:0] pc,
  input  logic [c8x_pkg::ADDR_W-1:0] index_reg,
  input  logic                      halted,
  output c8x_pkg::exec_res_t        res
);
  import c8x_pkg::*;

  logic [3:0]        op, n;
  logic [REG_AW-1:0] x;
  logic [DATA_W-1:0] kk;
  logic [ADDR_W-1:0] nnn, pc_step, pc_skip;
  logic              unknown;

  assign op      = instruction_word[15:12];
  assign x       = instruction_word[11:8];
  assign n       = instruction_word[3:0];
  assign kk      = instruction_word[7:0];
  assign nnn     = instruction_word[ADDR_W-1:0];
  assign pc_step = pc + PC_STEP;
  assign pc_skip = pc + PC_SKIP;

  always_comb begin
    res               = '0;
    res.next_pc       = pc;
    res.index_value   = index_reg;
    res.halted        = halted;
    res.status        = ST_DONE;
    unknown           = 1'b0;
    if (halted) begin
      res.status = ST_HALT;
    end else begin
      case (op)
        OP_SYS: begin
          if (instruction_word == INSTR_CLS || instruction_word == INSTR_RET) begin
            res.status = ST_UNIMPL;
          end else begin
            unknown = 1'b1;
          end
        end
        OP_JP:   res.next_pc = nnn;
        OP_CALL: res.status  = ST_UNIMPL;
        OP_SEB:  res.next_pc = (vx == kk) ? pc_skip : pc_step;
        OP_SNEB: res.next_pc = (vx != kk) ? pc_skip : pc_step;
        OP_SER:  res.next_pc = (vx == vy) ? pc_skip : pc_step;
        OP_SNER: res.next_pc = (vx != vy) ? pc_skip : pc_step;
        OP_LDB: begin
          res.reg_written   = 1'b1;
          res.written_value = kk;
        end
        OP_ADDB: begin
          res.reg_written   = 1'b1;
          res.written_value = vx + kk;
        end
        OP_ALU: begin
          res.reg_written = 1'b1;
          case (n)
            ALU_LD:  res.written_value = vy;
            ALU_OR:  res.written_value = vx | vy;
            ALU_AND: res.written_value = vx & vy;
            ALU_XOR: res.written_value = vx ^ vy;
            default: begin
              res.reg_written = 1'b0;
              unknown         = 1'b1;
            end
          endcase
        end
        OP_LDI: begin
          res.index_value = nnn;
          res.next_pc     = pc_step;
        end
        // vy carries V0 here: the top level steers read port B to V0
        OP_JPV0: res.next_pc = {{(ADDR_W-DATA_W){1'b0}}, vy} + nnn;
        OP_RND: begin
          res.reg_written   = 1'b1;
          res.written_value = random_byte & kk;
        end
        default: unknown = 1'b1;
      endcase
      if (unknown) begin
        res.halted = 1'b1;
        res.status = ST_HALT;
      end
      if (res.reg_written) begin
        res.written_index = x;
        res.next_pc       = pc_step;
      end
    end
  end

endmodule

/* rtl/core/chip8_instruction_execute_core.sv */
// CHIP-8 instruction execute core: top level with pipeline and state registers.
// Depends on c8x_pkg, c8x_if, c8x_regfile and c8x_exec.

// Executes one CHIP-8 instruction word per cycle, unless result back-pressure
// stalls it, and answers each with one result word: the next program
// counter (where the host fetches next), a status (0 executed,
// 1 CLS/RET/CALL not implemented, 2 unknown opcode or halted), the general
// register written, if any, and the index register I. Throughput is one
// instruction per clock while result.ready holds. An instruction word
// accepted at one edge has its V registers read from the register file
// memory at that edge; it executes while the output register is free, and
// its result word then enters the output register and raises result valid.
// The registered read of the register file and the output register lie
// between accept and result; a write that lands on the same edge as the
// next read is forwarded. The output register lets a new word enter while a
// result waits. An unknown opcode halts the core until reset: later words
// answer status 2 with the PC held. Writing cfg_wdata with cfg_we loads the
// PC; write it only while the core is idle. After reset the PC is 0x200, I
// and V0..VF are zero; no clearing pass is needed.
module chip8_instruction_execute_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [c8x_pkg::ADDR_W-1:0] cfg_wdata,
  c8x_instr_if.sink                 instr,
  c8x_result_if.source              result
);
  import c8x_pkg::*;

  // Architectural state outside the register file
  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] index_reg;
  logic              halted;

  // Execute stage: instruction waiting on its register reads
  logic              ex_valid;
  logic [WORD_W-1:0] ex_word;
  logic [DATA_W-1:0] ex_rnd;

  // Output register
  logic                out_valid;
  logic [ADDR_W-1:0]   out_next_pc;
  logic [STATUS_W-1:0] out_status;
  logic                out_reg_written;
  logic [REG_AW-1:0]   out_written_index;
  logic [DATA_W-1:0]   out_written_value;
  logic [ADDR_W-1:0]   out_index_value;

  logic              accept, advance;
  logic [REG_AW-1:0] rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0] vx, vy;
  exec_res_t         res;

  // Advance execute into the output register whenever the output is free
  assign advance     = ex_valid && (!out_valid || result.ready);
  assign instr.ready = !ex_valid || advance;
  assign accept      = instr.valid && instr.ready;

  // Port A reads Vx; port B reads Vy, or V0 for a JP V0,nnn
  assign rd_addr_a = instr.instruction_word[11:8];
  assign rd_addr_b = (instr.instruction_word[15:12] == OP_JPV0) ?
                     '0 : instr.instruction_word[7:4];

  c8x_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (vx),
    .rd_data_b (vy),
    .wr_en     (advance && res.reg_written),
    .wr_addr   (res.written_index),
    .wr_data   (res.written_value)
  );

  c8x_exec u_exec (
    .instruction_word (ex_word),
    .random_byte      (ex_rnd),
    .vx               (vx),
    .vy               (vy),
    .pc               (pc),
    .index_reg        (index_reg),
    .halted           (halted),
    .res              (res)
  );

  // Hold the instruction payload until it executes
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_word <= instr.instruction_word;
      ex_rnd  <= instr.random_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (accept) begin
      ex_valid <= 1'b1;
    end else if (advance) begin
      ex_valid <= 1'b0;
    end
  end

  // Commit state; user must send a config write only while idle; not checked
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= START_RESET;
      index_reg <= '0;
      halted    <= 1'b0;
    end else begin
      if (advance) begin
        pc        <= res.next_pc;
        index_reg <= res.index_value;
        halted    <= res.halted;
      end
      if (cfg_we) begin
        pc <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_next_pc       <= res.next_pc;
      out_status        <= res.status;
      out_reg_written   <= res.reg_written;
      out_written_index <= res.written_index;
      out_written_value <= res.written_value;
      out_index_value   <= res.index_value;
    end
  end

  assign result.valid         = out_valid;
  assign result.next_pc       = out_next_pc;
  assign result.status        = out_status;
  assign result.reg_written   = out_reg_written;
  assign result.written_index = out_written_index;
  assign result.written_value = out_written_value;
  assign result.index_value   = out_index_value;

endmodule
